// ===== rtl/nms_pkg.sv =====
package nms_pkg;

	localparam int MaxBoxesDefault = 64;
	localparam int ResultCap = 64;
	localparam logic [15:0] IouLimitReset = 16'd26214;
	localparam logic [17:0] OnePixel = 18'd16;

	typedef struct packed {
		logic signed [15:0] box_left;
		logic signed [15:0] box_top;
		logic [14:0] box_width;
		logic [14:0] box_height;
		logic [15:0] box_score;
		logic final_box;
	} box_in_t;

	typedef struct packed {
		logic [5:0] kept_index;
		logic [15:0] kept_score;
		logic final_kept;
		logic overflowed;
	} box_out_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_PICK,
		ST_SUPP,
		ST_SUPP_WAIT,
		ST_EMIT,
		ST_DONE
	} nms_state_t;

	// controller -> datapath
	typedef struct packed {
		logic store_box;
		logic clear_flags;
		logic scan_start;
		logic scan_step;
		logic keep_best;
		logic supp_start;
		logic supp_step;
		logic load_out;
		logic end_batch;
	} nms_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic found;
		logic supp_last;
		logic clear_last;
		logic cap_reached;
	} nms_status_t;

endpackage

// ===== rtl/nms_ctrl.sv =====
module nms_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_final,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  nms_pkg::nms_status_t status,
	output nms_pkg::nms_cmd_t cmd
);
	nms_pkg::nms_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nms_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			nms_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store_box = 1'b1;
					if (in_final) begin
						state_d = nms_pkg::ST_CLEAR;
					end
				end
			end
			nms_pkg::ST_CLEAR: begin
				cmd.clear_flags = 1'b1;
				cmd.scan_start = 1'b1;
				state_d = nms_pkg::ST_SCAN;
			end
			nms_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = nms_pkg::ST_SCAN_WAIT;
				end
			end
			nms_pkg::ST_SCAN_WAIT: begin
				// last scan read in flight
				cmd.scan_step = 1'b1;
				state_d = nms_pkg::ST_PICK;
			end
			nms_pkg::ST_PICK: begin
				if (status.found && !status.cap_reached) begin
					cmd.keep_best = 1'b1;
					cmd.supp_start = 1'b1;
					state_d = nms_pkg::ST_SUPP;
				end else begin
					state_d = nms_pkg::ST_DONE;
				end
			end
			nms_pkg::ST_SUPP: begin
				cmd.supp_step = 1'b1;
				if (status.supp_last) begin
					state_d = nms_pkg::ST_SUPP_WAIT;
				end
			end
			nms_pkg::ST_SUPP_WAIT: begin
				cmd.supp_step = 1'b1;
				if (status.clear_last) begin
					cmd.load_out = 1'b1;
					state_d = nms_pkg::ST_EMIT;
				end
			end
			nms_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.scan_start = 1'b1;
					state_d = nms_pkg::ST_SCAN;
				end
			end
			nms_pkg::ST_DONE: begin
				cmd.end_batch = 1'b1;
				state_d = nms_pkg::ST_LOAD;
			end
			default: state_d = nms_pkg::ST_LOAD;
		endcase
	end

endmodule

// ===== rtl/nms_datapath.sv =====
module nms_datapath #(
	parameter int MAX_BOXES = nms_pkg::MaxBoxesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  nms_pkg::box_in_t box_in,
	input  logic [15:0] iou_limit,
	input  nms_pkg::nms_cmd_t cmd,
	output nms_pkg::nms_status_t status,
	output nms_pkg::box_out_t box_out
);
	localparam int IdxW = $clog2(MAX_BOXES);
	localparam int CntW = $clog2(MAX_BOXES + 1);
	localparam int KeepW = $clog2(nms_pkg::ResultCap + 1);

	// one memory, one write port, one read port
	logic [77:0] mem [MAX_BOXES];
	logic [77:0] rd_s1;
	logic [MAX_BOXES-1:0] drop_q;

	logic [CntW-1:0] count_q;
	logic ovf_q;
	logic [CntW-1:0] ptr_q;
	logic [IdxW-1:0] rd_idx_s1;
	logic rd_vld_s1;

	logic found_q;
	logic [IdxW-1:0] best_q;
	logic [15:0] best_score_q;
	logic [77:0] best_row_q;
	logic [77:0] kept_q;
	logic [IdxW-1:0] kept_idx_q;
	logic [KeepW-1:0] nkept_q;

	logic [5:0] out_idx_q;
	logic [15:0] out_score_q;
	logic out_ovf_q;
	logic out_final;

	// suppression pipe stages
	logic signed [17:0] iw_s2, ih_s2;
	logic [31:0] ak_s2, aj_s2;
	logic vld_s2;
	logic [IdxW-1:0] idx_s2;
	logic [35:0] inter_s3;
	logic [32:0] asum_s3;
	logic vld_s3;
	logic [IdxW-1:0] idx_s3;
	logic signed [37:0] uni_s4;
	logic [35:0] inter_s4;
	logic vld_s4;
	logic [IdxW-1:0] idx_s4;
	logic vld_s5;
	logic drop_s5;
	logic [IdxW-1:0] idx_s5;
	logic pipe_busy;

	logic scanning;
	assign scanning = cmd.scan_step;

	always_ff @(posedge clk) begin
		if (cmd.store_box && count_q < CntW'(MAX_BOXES)) begin
			mem[count_q[IdxW-1:0]] <= {box_in.box_left, box_in.box_top, box_in.box_width,
				box_in.box_height, box_in.box_score};
		end
		rd_s1 <= mem[ptr_q[IdxW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			ptr_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			nkept_q <= '0;
			drop_q <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (cmd.store_box) begin
				if (count_q < CntW'(MAX_BOXES)) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.clear_flags) begin
				drop_q <= '0;
				nkept_q <= '0;
			end
			if (cmd.scan_start || cmd.supp_start) begin
				ptr_q <= '0;
				found_q <= 1'b0;
			end
			if ((scanning || cmd.supp_step) && ptr_q < count_q) begin
				ptr_q <= ptr_q + 1'b1;
				rd_vld_s1 <= 1'b1;
			end
			if (scanning && rd_vld_s1 && !drop_q[rd_idx_s1]) begin
				if (!found_q || rd_s1[15:0] > best_score_q) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.keep_best) begin
				drop_q[best_q] <= 1'b1;
				nkept_q <= nkept_q + 1'b1;
			end
			vld_s2 <= cmd.supp_step && rd_vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			if (vld_s5 && drop_s5) begin
				drop_q[idx_s5] <= 1'b1;
			end
			if (cmd.end_batch) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q[IdxW-1:0];
		if (scanning && rd_vld_s1 && !drop_q[rd_idx_s1]) begin
			if (!found_q || rd_s1[15:0] > best_score_q) begin
				best_q <= rd_idx_s1;
				best_score_q <= rd_s1[15:0];
				best_row_q <= rd_s1;
			end
		end
		if (cmd.keep_best) begin
			kept_idx_q <= best_q;
			kept_q <= best_row_q;
		end
	end

	// kept box row latched when it is picked
	logic [77:0] kb;
	logic signed [17:0] kl, kt, jl, jt, kr, kbm, jr, jbm, x1, y1, x2, y2;
	always_comb begin
		kb = kept_q;
		kl = 18'(signed'(kb[77:62]));
		kt = 18'(signed'(kb[61:46]));
		jl = 18'(signed'(rd_s1[77:62]));
		jt = 18'(signed'(rd_s1[61:46]));
		kr = kl + 18'(kb[45:31]);
		kbm = kt + 18'(kb[30:16]);
		jr = jl + 18'(rd_s1[45:31]);
		jbm = jt + 18'(rd_s1[30:16]);
		x1 = (kl > jl) ? kl : jl;
		y1 = (kt > jt) ? kt : jt;
		x2 = (kr < jr) ? kr : jr;
		y2 = (kbm < jbm) ? kbm : jbm;
	end

	logic signed [17:0] dw, dh;
	assign dw = x2 - x1 + signed'(nms_pkg::OnePixel);
	assign dh = y2 - y1 + signed'(nms_pkg::OnePixel);

	logic drop_cond;
	assign drop_cond = (64'(inter_s4) << 16) > (64'(iou_limit) * 64'(uni_s4));

	always_ff @(posedge clk) begin
		iw_s2 <= (dw > 0) ? dw : '0;
		ih_s2 <= (dh > 0) ? dh : '0;
		ak_s2 <= 32'(16'(kb[45:31]) + 16'd16) * 32'(16'(kb[30:16]) + 16'd16);
		aj_s2 <= 32'(16'(rd_s1[45:31]) + 16'd16) * 32'(16'(rd_s1[30:16]) + 16'd16);
		idx_s2 <= rd_idx_s1;
		inter_s3 <= 36'(iw_s2[16:0]) * 36'(ih_s2[16:0]);
		asum_s3 <= 33'(ak_s2) + 33'(aj_s2);
		idx_s3 <= idx_s2;
		uni_s4 <= signed'(38'(asum_s3)) - signed'(38'(inter_s3));
		inter_s4 <= inter_s3;
		idx_s4 <= idx_s3;
		drop_s5 <= (uni_s4 > 0) && drop_cond;
		idx_s5 <= idx_s4;
	end

	assign pipe_busy = rd_vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_idx_q <= 6'(kept_idx_q);
			out_score_q <= kept_q[15:0];
			out_ovf_q <= ovf_q;
		end
	end

	// final flag resolved when emitting: decided by a lookahead done after suppression
	logic any_left;
	always_comb begin
		any_left = 1'b0;
		for (int i = 0; i < MAX_BOXES; i++) begin
			if (CntW'(i) < count_q && !drop_q[i]) any_left = 1'b1;
		end
	end
	assign out_final = !any_left || (nkept_q == KeepW'(nms_pkg::ResultCap));

	assign box_out.kept_index = out_idx_q;
	assign box_out.kept_score = out_score_q;
	assign box_out.final_kept = out_final;
	assign box_out.overflowed = out_ovf_q;

	assign status.scan_last = (ptr_q >= count_q);
	assign status.found = found_q;
	assign status.supp_last = (ptr_q >= count_q);
	assign status.clear_last = !pipe_busy;
	assign status.cap_reached = (nkept_q == KeepW'(nms_pkg::ResultCap));

endmodule

// ===== rtl/nms_box_suppression.sv =====
// Greedy NMS over a batch of boxes.
// Input channel: one box per item on in_valid/in_ready; final_box closes
// the batch. Boxes past MAX_BOXES are dropped and flag overflowed.
// After the final box the block clears drop flags, then per kept box:
// a score scan over the box memory (one memory read a cycle)
// and an IoU pass through a 5-stage pipe, then one result.
// in_ready is high while loading and low from the final box until the
// closing scan after the last result ends.
// Output channel: out_valid/out_ready carries kept index, score, a final
// flag on the last result and the overflow flag. A stalled receiver holds
// the result and the batch in place.
// Reset clears control state and loads iou_limit with its default;
// box memory contents are undefined until written.
// Config: APB register 0 at address 0 is iou_limit.
module nms_box_suppression #(
	parameter int MAX_BOXES = nms_pkg::MaxBoxesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  nms_pkg::box_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output nms_pkg::box_out_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [15:0] iou_limit_q;
	nms_pkg::nms_cmd_t cmd;
	nms_pkg::nms_status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'd0, iou_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_limit_q <= nms_pkg::IouLimitReset;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			iou_limit_q <= pwdata[15:0];
		end
	end

	nms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_final(in_data.final_box),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cmd(cmd)
	);

	nms_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
		.clk(clk), .arst_n(arst_n), .box_in(in_data), .iou_limit(iou_limit_q),
		.cmd(cmd), .status(status), .box_out(out_data)
	);

endmodule

// ===== rtl/nms_checker.sv =====
module nms_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input nms_pkg::box_out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result moved while stalled");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input open during emission");
	a_final_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.final_kept |=> !in_ready)
		else $error("input reopened mid batch");
endmodule

bind nms_box_suppression nms_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/sv/nms_box_suppression_test.sv =====
`default_nettype none

module nms_box_suppression_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BoxCap = nms_pkg::MaxBoxesDefault;
	localparam logic [1:0] IouLimitAddr = 2'd0;
	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	nms_pkg::box_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	nms_pkg::box_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	nms_box_suppression DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	nms_pkg::box_in_t pending_boxes[$];
	nms_pkg::box_out_t kept_expected[$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int errors = 0;
	int cycles = 0;
	int boxes_taken = 0;
	int batches_closed = 0;
	int results_checked = 0;
	bit in_taken = 1'b0;

	// predictor copy of the block state
	logic [15:0] thresh = nms_pkg::IouLimitReset;
	int bx_left[BoxCap];
	int bx_top[BoxCap];
	int bx_w[BoxCap];
	int bx_h[BoxCap];
	int bx_score[BoxCap];
	int stored = 0;
	bit spilled = 1'b0;

	initial forever #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	task automatic queue_box(nms_pkg::box_in_t b);
		pending_boxes = {pending_boxes, b};
	endtask

	function automatic bit suppresses(int k, int j);
		longint x1, y1, x2, y2, iw, ih, inter, uni;
		x1 = (bx_left[k] > bx_left[j]) ? bx_left[k] : bx_left[j];
		y1 = (bx_top[k] > bx_top[j]) ? bx_top[k] : bx_top[j];
		x2 = longint'(bx_left[k]) + bx_w[k];
		if (longint'(bx_left[j]) + bx_w[j] < x2)
			x2 = longint'(bx_left[j]) + bx_w[j];
		y2 = longint'(bx_top[k]) + bx_h[k];
		if (longint'(bx_top[j]) + bx_h[j] < y2)
			y2 = longint'(bx_top[j]) + bx_h[j];
		iw = x2 - x1 + 16;
		ih = y2 - y1 + 16;
		if (iw < 0)
			iw = 0;
		if (ih < 0)
			ih = 0;
		inter = iw * ih;
		uni = longint'(bx_w[k] + 16) * (bx_h[k] + 16)
			+ longint'(bx_w[j] + 16) * (bx_h[j] + 16) - inter;
		if (uni <= 0)
			return 1'b0;
		return inter * 65536 > longint'(thresh) * uni;
	endfunction

	task automatic accept_box(nms_pkg::box_in_t b);
		bit gone[BoxCap];
		int best, count;
		nms_pkg::box_out_t r;
		if (stored < BoxCap) begin
			bx_left[stored] = int'(b.box_left);
			bx_top[stored] = int'(b.box_top);
			bx_w[stored] = int'(b.box_width);
			bx_h[stored] = int'(b.box_height);
			bx_score[stored] = int'(b.box_score);
			stored++;
		end else
			spilled = 1'b1;
		if (!b.final_box)
			return;
		for (int i = 0; i < BoxCap; i++)
			gone[i] = 1'b0;
		count = 0;
		while (count < nms_pkg::ResultCap) begin
			best = -1;
			for (int i = 0; i < stored; i++)
				if (!gone[i] && (best < 0 || bx_score[i] > bx_score[best]))
					best = i;
			if (best < 0)
				break;
			gone[best] = 1'b1;
			for (int i = 0; i < stored; i++)
				if (!gone[i] && suppresses(best, i))
					gone[i] = 1'b1;
			r.kept_index = 6'(best);
			r.kept_score = 16'(bx_score[best]);
			r.final_kept = 1'b0;
			r.overflowed = spilled;
			kept_expected = {kept_expected, r};
			count++;
		end
		if (count > 0)
			kept_expected[$].final_kept = 1'b1;
		stored = 0;
		spilled = 1'b0;
		batches_closed++;
	endtask

	// monitor and predictor
	always @(posedge clk) begin
		nms_pkg::box_out_t want;
		in_taken = in_valid && in_ready && arst_n;
		if (arst_n && out_valid && out_ready) begin
			if (kept_expected.size() == 0) begin
				report("unexpected result index", out_data.kept_index, -1);
			end else begin
				want = kept_expected.pop_front();
				results_checked++;
				if (out_data.kept_index != want.kept_index)
					report("kept_index", out_data.kept_index, want.kept_index);
				if (out_data.kept_score != want.kept_score)
					report("kept_score", out_data.kept_score, want.kept_score);
				if (out_data.final_kept != want.final_kept)
					report("final_kept", out_data.final_kept, want.final_kept);
				if (out_data.overflowed != want.overflowed)
					report("overflowed", out_data.overflowed, want.overflowed);
			end
		end
		if (in_taken) begin
			boxes_taken++;
			accept_box(in_data);
		end
	end

	// driver
	always @(negedge clk) begin
		if (in_valid && !in_taken)
			in_valid <= 1'b1;
		else if (pending_boxes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
			in_data <= pending_boxes.pop_front();
			in_valid <= 1'b1;
		end else
			in_valid <= 1'b0;
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	function automatic nms_pkg::box_in_t make_box(int l, int t, int w, int h, int s,
		bit fin);
		nms_pkg::box_in_t b;
		b.box_left = 16'(l);
		b.box_top = 16'(t);
		b.box_width = 15'(w);
		b.box_height = 15'(h);
		b.box_score = 16'(s);
		b.final_box = fin;
		return b;
	endfunction

	// clustered boxes overlap often; wild ones use every bit of every field
	task automatic add_batch(int n, bit wild);
		int cx, cy, s;
		cx = $urandom_range(4000) - 2000;
		cy = $urandom_range(4000) - 2000;
		for (int i = 0; i < n; i++) begin
			s = ($urandom_range(3) == 0) ? 100 * $urandom_range(1, 2) : $urandom_range(65535);
			if (wild)
				queue_box(make_box($urandom, $urandom, $urandom,
					$urandom, s, i == n - 1));
			else
				queue_box(make_box(cx + $urandom_range(200) - 100,
					cy + $urandom_range(200) - 100, $urandom_range(160, 900),
					$urandom_range(160, 900), s, i == n - 1));
		end
	endtask

	task automatic wait_idle();
		while (pending_boxes.size() > 0 || in_valid || kept_expected.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = IouLimitAddr;
		pwdata = {16'd0, v};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		thresh = v;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	initial begin
		logic [15:0] limits[4];
		int added;
		limits = '{16'hFFFF, 16'h0000, 16'h0000, 16'h8000};
		limits[2] = 16'($urandom);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 38;
		rx_idle_pct = 85;
		// lone box at the field extremes
		queue_box(make_box(-32768, 32767, 32767, 0, 65535, 1'b1));
		// equal scores, identical boxes: lower index wins, other dropped
		queue_box(make_box(100, 100, 320, 320, 5000, 1'b0));
		queue_box(make_box(100, 100, 320, 320, 5000, 1'b1));
		// far-right edges and touching boxes, zero score, ascending scores
		queue_box(make_box(32767, -32768, 32767, 32767, 0, 1'b0));
		queue_box(make_box(0, 0, 160, 160, 10, 1'b0));
		queue_box(make_box(176, 0, 160, 160, 20, 1'b0));
		queue_box(make_box(160, 0, 160, 160, 30, 1'b0));
		queue_box(make_box(-500, -500, 0, 0, 65535, 1'b1));
		// partial overlap cluster
		queue_box(make_box(0, 0, 640, 640, 900, 1'b0));
		queue_box(make_box(64, 64, 640, 640, 800, 1'b0));
		queue_box(make_box(320, 320, 640, 640, 700, 1'b0));
		queue_box(make_box(-16, 0, 640, 640, 900, 1'b1));
		wait_idle();

		for (int c = 0; c < 4; c++) begin
			write_limit(limits[c]);
			tx_idle_pct = (c == 0) ? 38 : (c == 1) ? 85 : 0;
			rx_idle_pct = (c == 0) ? 85 : (c == 1) ? 38 : 0;
			if (c == 3)
				add_batch(BoxCap + 2, 1'b1);
			added = 0;
			while (added < 3) begin
				int n;
				n = $urandom_range(1, 8);
				add_batch(n, $urandom_range(5) == 0);
				added += n;
			end
			wait_idle();
		end
		write_limit(nms_pkg::IouLimitReset);
		add_batch(6, 1'b0);
		wait_idle();

		$display("%0d boxes in %0d batches, %0d kept results checked", boxes_taken,
			batches_closed, results_checked);
		$display("thresholds from 0 to full scale, overflow batch, three idle patterns");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
